FILE: rtl/hsc_pkg.sv
`default_nettype none

package hsc_pkg;

    localparam int DATA_MAX   = 57;
    localparam int PARITY_MAX = 6;
    localparam int WORD_W     = 63;
    localparam int SYN_W      = 6;
    localparam int CFG_W      = 6;
    localparam int PAR_W      = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(DATA_MAX);

    typedef enum logic [0:0] {
        FUNC_ENCODE = 1'b0,
        FUNC_DECODE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_CORRECTED     = 2'd1,
        ST_UNCORRECTABLE = 2'd2
    } t_status;

    // derived code geometry, refreshed on every register write
    typedef struct packed {
        logic [DATA_MAX-1:0] data_mask;
        logic [WORD_W-1:0]   code_mask;
        logic [SYN_W-1:0]    code_len;
    } t_cfg;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [SYN_W-1:0]  syndrome;
        t_status           status;
    } t_result;

    // bit index of every data bit in the codeword (non power-of-two positions)
    typedef logic [SYN_W-1:0] t_pos_tab [DATA_MAX];

    function automatic t_pos_tab f_data_pos();
        t_pos_tab tab;
        int       j;
        j = 0;
        for (int i = 0; i < DATA_MAX; i++) begin
            tab[i] = '0;
        end
        for (int p = 1; p <= WORD_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (j < DATA_MAX) begin
                    tab[j] = SYN_W'(p - 1);
                end
                j++;
            end
        end
        return tab;
    endfunction

    localparam t_pos_tab DATA_POS = f_data_pos();

    // xor of the 1-based positions of all set bits
    function automatic logic [SYN_W-1:0] f_syndrome(input logic [WORD_W-1:0] cw);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int p = 1; p <= WORD_W; p++) begin
            if (cw[p-1]) begin
                s = s ^ SYN_W'(p);
            end
        end
        return s;
    endfunction

    function automatic t_cfg f_cfg(input logic [CFG_W-1:0] value);
        t_cfg        c;
        int          n;
        int          r;
        logic [63:0] one;
        one = 64'd1;
        n   = int'(value);
        if (n < 1) begin
            n = 1;
        end
        if (n > DATA_MAX) begin
            n = DATA_MAX;
        end
        // smallest parity count that covers the data, capped
        r = 0;
        for (int k = 0; k < PARITY_MAX; k++) begin
            if ((1 << r) < n + r + 1) begin
                r++;
            end
        end
        c.data_mask = DATA_MAX'((one << n) - 64'd1);
        c.code_mask = WORD_W'((one << (n + r)) - 64'd1);
        c.code_len  = SYN_W'(n + r);
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/hsc_cfg.sv
`default_nettype none

module hsc_cfg (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [hsc_pkg::CFG_W-1:0] i_cfg_data,
    output hsc_pkg::t_cfg                  o_cfg
);
    import hsc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // geometry worked out once per write, not per word
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            n_cfg = f_cfg(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= f_cfg(CFG_RESET);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/hsc_datapath.sv
`default_nettype none

module hsc_datapath (
    input  wire logic                       i_func,
    input  wire logic [hsc_pkg::WORD_W-1:0] i_word,
    input  wire hsc_pkg::t_cfg              i_cfg,
    output hsc_pkg::t_result                o_result
);
    import hsc_pkg::*;

    logic [DATA_MAX-1:0] enc_data;
    logic [WORD_W-1:0]   enc_cw;
    logic [SYN_W-1:0]    enc_syn;
    logic [WORD_W-1:0]   dec_cw;
    logic [SYN_W-1:0]    dec_syn;
    logic                dec_flip;
    logic [WORD_W-1:0]   dec_fixed;
    logic [DATA_MAX-1:0] dec_data;
    t_status             dec_status;

    // encode: scatter data, parity bits from the data-only syndrome
    always_comb begin
        enc_data = i_word[DATA_MAX-1:0] & i_cfg.data_mask;
        enc_cw   = '0;
        for (int j = 0; j < DATA_MAX; j++) begin
            enc_cw[DATA_POS[j]] = enc_data[j];
        end
        enc_syn = f_syndrome(enc_cw);
        for (int i = 0; i < PARITY_MAX; i++) begin
            enc_cw[(1 << i) - 1] = enc_syn[i];
        end
        enc_cw = enc_cw & i_cfg.code_mask;
    end

    // decode: syndrome, single-bit fix, gather
    always_comb begin
        dec_cw     = i_word & i_cfg.code_mask;
        dec_syn    = f_syndrome(dec_cw);
        dec_flip   = 1'b0;
        dec_status = ST_OK;
        if (dec_syn != '0) begin
            if (dec_syn <= i_cfg.code_len) begin
                dec_flip   = 1'b1;
                dec_status = ST_CORRECTED;
            end else begin
                dec_status = ST_UNCORRECTABLE;
            end
        end
        dec_fixed = dec_cw;
        if (dec_flip) begin
            dec_fixed = dec_cw ^ (WORD_W'(1) << (dec_syn - SYN_W'(1)));
        end
        for (int j = 0; j < DATA_MAX; j++) begin
            dec_data[j] = dec_fixed[DATA_POS[j]];
        end
        dec_data = dec_data & i_cfg.data_mask;
    end

    always_comb begin
        if (i_func == FUNC_DECODE) begin
            o_result.word     = WORD_W'(dec_data);
            o_result.syndrome = dec_syn;
            o_result.status   = dec_status;
        end else begin
            o_result.word     = enc_cw;
            o_result.syndrome = '0;
            o_result.status   = ST_OK;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hamming_sec_codec_core.sv
// hamming_sec_codec_core: even-parity hamming single-error-correcting codec
//
// input channel (i_in_valid / o_in_ready) carries one word: i_func selects
// encode or decode, i_word_in holds data bits or a codeword (bit k is
// position k+1). output channel (o_out_valid / i_out_ready) returns the
// codeword or the corrected data bits, the syndrome and a status code.
// i_cfg_we writes the data length; the parity count and code length are
// derived from it on the write. write it only while the codec is empty.
//
// path: an accepted word is registered in the input stage, worked through
// the xor trees and scatter/gather logic, and loaded into the output
// register, from which it is offered to the receiver.
// throughput: one word per cycle while the receiver is ready, set by the
// two-register pipeline.
// when the receiver stalls, the output register holds its word and the input
// register keeps the next one; o_in_ready drops only when both are full and
// the receiver is not ready.
// reset empties the pipeline and sets the data length to 57 bits.

`default_nettype none

module hamming_sec_codec_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [hsc_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                        i_in_valid,
    output wire logic                        o_in_ready,
    input  wire logic                        i_func,
    input  wire logic [hsc_pkg::WORD_W-1:0]  i_word_in,
    output wire logic                        o_out_valid,
    input  wire logic                        i_out_ready,
    output wire logic [hsc_pkg::WORD_W-1:0]  o_word_out,
    output wire logic [hsc_pkg::SYN_W-1:0]   o_syndrome_value,
    output wire logic [1:0]                  o_status
);
    import hsc_pkg::*;

    t_cfg cfg;

    // input stage
    logic              r_s1_valid;
    logic              n_s1_valid;
    logic              r_s1_func;
    logic [WORD_W-1:0] r_s1_word;

    // result stage
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result result;

    logic out_load;
    logic in_take;

    hsc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    hsc_datapath u_datapath (
        .i_func   (r_s1_func),
        .i_word   (r_s1_word),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // output register may take a new word when empty or being drained
    assign out_load   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || out_load;
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = r_s1_valid;
        end
        if (o_in_ready) begin
            n_s1_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_func <= i_func;
            r_s1_word <= i_word_in;
        end
        if (out_load && r_s1_valid) begin
            r_out <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_word_out       = r_out.word;
    assign o_syndrome_value = r_out.syndrome;
    assign o_status         = r_out.status;

    // a clean word never carries a syndrome
    a_ok_zero_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_OK |-> r_out.syndrome == '0)
        else $error("clean word with non-zero syndrome");

    // a correction always points inside the code
    a_corr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_CORRECTED |->
            r_out.syndrome != '0 && r_out.syndrome <= cfg.code_len)
        else $error("correction outside code length");

    // uncorrectable only when the syndrome lies past the code
    a_uncorr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_UNCORRECTABLE |->
            r_out.syndrome > cfg.code_len)
        else $error("uncorrectable flag with syndrome in range");

    // an empty input stage always takes a word
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_in_ready)
        else $error("input stalled while empty");

    // a word waiting in the input stage moves on as soon as the output drains
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && out_load |=> r_out_valid)
        else $error("input stage word lost");

endmodule

`default_nettype wire
